/* sv/ht64_pkg.sv */
// ============================================================================
// ht64_pkg
// Shared types, constants and functions for the hex text to base64 encoder.
// ============================================================================
package ht64_pkg;

    localparam int CHAR_W   = 8;
    localparam int NIB_W    = 4;
    localparam int CNT_W    = 2;
    localparam int GRP_N    = 4;   // most results one input beat can cause
    localparam int IDX_W    = 2;
    localparam int USER_W   = 2;

    localparam logic [CHAR_W-1:0] CH_PAD  = 8'h3D;  // '='
    localparam logic [CHAR_W-1:0] CH_0    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9    = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UF   = 8'h46;

    localparam logic [CNT_W-1:0] CNT_NONE = 2'd0;
    localparam logic [CNT_W-1:0] CNT_ONE  = 2'd1;
    localparam logic [CNT_W-1:0] CNT_TWO  = 2'd2;

    localparam logic [IDX_W-1:0] IDX_LAST_TWO  = 2'd1;
    localparam logic [IDX_W-1:0] IDX_LAST_FOUR = 2'd3;

    // One set of results produced from a single input beat.
    typedef struct packed {
        logic                          valid;  // at least one result
        logic                          four;   // four results, else two
        logic                          err;
        logic                          word_end;
        logic [GRP_N-1:0][CHAR_W-1:0]  chars;  // entry 0 goes out first
    } t_group;

    // Carried word state between input beats.
    typedef struct packed {
        logic [2*NIB_W-1:0] held;
        logic [CNT_W-1:0]   cnt;
        logic               err;
    } t_word_state;

    // Standard base64 alphabet.
    function automatic logic [CHAR_W-1:0] b64_char(input logic [5:0] idx);
        logic [CHAR_W-1:0] ch;
        if (idx < 6'd26) begin
            ch = 8'h41 + {2'b00, idx};
        end else if (idx < 6'd52) begin
            ch = 8'h61 + {2'b00, idx - 6'd26};
        end else if (idx < 6'd62) begin
            ch = 8'h30 + {2'b00, idx - 6'd52};
        end else if (idx == 6'd62) begin
            ch = 8'h2B;
        end else begin
            ch = 8'h2F;
        end
        return ch;
    endfunction

    // Hex digit value; anything that is not 0-9 or A-F reads as one.
    function automatic logic [NIB_W:0] hex_decode(input logic [CHAR_W-1:0] c);
        logic [NIB_W:0] r;  // {bad, value}
        if (c >= CH_0 && c <= CH_9) begin
            r = {1'b0, NIB_W'(c - CH_0)};
        end else if (c >= CH_UA && c <= CH_UF) begin
            r = {1'b0, NIB_W'(c - CH_UA + 8'd10)};
        end else begin
            r = {1'b1, NIB_W'(1)};
        end
        return r;
    endfunction

endpackage

/* sv/ht64_encode.sv */
// ============================================================================
// ht64_encode
// Turns one registered hex character and the carried word state into the
// group of base64 results it causes and the next word state.
// ============================================================================
module ht64_encode (
    input  logic [ht64_pkg::CHAR_W-1:0] i_hex_char,
    input  logic                        i_word_end,
    input  ht64_pkg::t_word_state       i_state,
    output ht64_pkg::t_group            o_group,
    output ht64_pkg::t_word_state       o_state
);

    logic [ht64_pkg::NIB_W:0]   dec;
    logic [ht64_pkg::NIB_W-1:0] nib;
    logic                       bad;
    logic                       err;
    logic [ht64_pkg::CNT_W-1:0] cnt;
    logic [11:0]                bits;

    always_comb begin
        dec = ht64_pkg::hex_decode(i_hex_char);
        nib = dec[ht64_pkg::NIB_W-1:0];
        bad = dec[ht64_pkg::NIB_W];
        err = i_state.err | bad;
        // A count of three cannot happen; treat it like two.
        cnt = (i_state.cnt == 2'd3) ? ht64_pkg::CNT_TWO : i_state.cnt;

        o_group          = '0;
        o_group.err      = err;
        o_group.word_end = i_word_end;
        o_state          = i_state;
        bits             = '0;

        if (cnt == ht64_pkg::CNT_TWO) begin
            // Three nibbles complete: two characters.
            bits             = {i_state.held, nib};
            o_group.valid    = 1'b1;
            o_group.chars[0] = ht64_pkg::b64_char(bits[11:6]);
            o_group.chars[1] = ht64_pkg::b64_char(bits[5:0]);
            o_state.held     = '0;
            o_state.cnt      = ht64_pkg::CNT_NONE;
        end else if (i_word_end) begin
            o_group.valid = 1'b1;
            if (cnt == ht64_pkg::CNT_NONE) begin
                o_group.chars[0] = ht64_pkg::b64_char({nib, 2'b00});
                o_group.chars[1] = ht64_pkg::CH_PAD;
            end else begin
                bits             = {i_state.held[ht64_pkg::NIB_W-1:0], nib, 4'b0000};
                o_group.four     = 1'b1;
                o_group.chars[0] = ht64_pkg::b64_char(bits[11:6]);
                o_group.chars[1] = ht64_pkg::b64_char(bits[5:0]);
                o_group.chars[2] = ht64_pkg::CH_PAD;
                o_group.chars[3] = ht64_pkg::CH_PAD;
            end
        end else begin
            o_state.held = {i_state.held[ht64_pkg::NIB_W-1:0], nib};
            o_state.cnt  = cnt + ht64_pkg::CNT_ONE;
        end

        if (i_word_end) begin
            o_state = '0;
        end else begin
            o_state.err = err;
        end
    end

endmodule

/* sv/hex_text_to_base64_encoder.sv */
// ============================================================================
// hex_text_to_base64_encoder
// Re-encodes a stream of ASCII hex digits, one word at a time, as base64
// characters with '=' padding where a word ends part way through a three-digit group.
// ============================================================================
//
// Channel   Dir  tdata           tuser                       tlast
// s_axis    in   hex_char[7:0]   (none)                      word_end
// m_axis    out  out_char[7:0]   [0] word_done, [1] bad      run_last
//
// Each input beat is captured in an input register and encoded from there
// into a group of zero, two or four output characters held in a group
// register. The group drains one output beat per cycle while m_axis_tready
// is high. Beats that only store a nibble are taken one per cycle; a beat
// that causes results waits until the previous group has drained or its
// last character is being taken.
// A beat that only stores a nibble passes through without using the group
// register. Reset (i_rst_n low at a clock edge) empties both stages and
// clears the carried nibbles and the error flag. Stalls on m_axis back up
// into s_axis tready within the same cycle.
module hex_text_to_base64_encoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [ht64_pkg::CHAR_W-1:0]   s_axis_tdata,   // [7:0] hex_char
    input  logic                          s_axis_tlast,   // word_end
    // Output stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [ht64_pkg::CHAR_W-1:0]   m_axis_tdata,   // [7:0] out_char
    output logic [ht64_pkg::USER_W-1:0]   m_axis_tuser,   // [0] word_done, [1] bad_digit_seen
    output logic                          m_axis_tlast    // run_last
);

    // Input register.
    logic                        r_in_valid;
    logic [ht64_pkg::CHAR_W-1:0] r_in_char;
    logic                        r_in_end;

    // Carried word state.
    ht64_pkg::t_word_state       r_state;
    ht64_pkg::t_word_state       n_state;

    // Group register and its drain index.
    ht64_pkg::t_group            r_grp;
    ht64_pkg::t_group            n_grp;
    logic [ht64_pkg::IDX_W-1:0]  r_idx;

    logic                        out_fire;
    logic                        grp_last;
    logic                        grp_free;
    logic                        advance;

    ht64_encode u_encode (
        .i_hex_char (r_in_char),
        .i_word_end (r_in_end),
        .i_state    (r_state),
        .o_group    (n_grp),
        .o_state    (n_state)
    );

    assign grp_last = (r_idx == (r_grp.four ? ht64_pkg::IDX_LAST_FOUR
                                            : ht64_pkg::IDX_LAST_TWO));
    assign out_fire = m_axis_tvalid && m_axis_tready;
    assign grp_free = !r_grp.valid || (out_fire && grp_last);
    // A beat that makes no results never waits for the output side.
    assign advance  = r_in_valid && (!n_grp.valid || grp_free);

    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_char <= s_axis_tdata;
            r_in_end  <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp.valid <= 1'b0;
            r_idx       <= '0;
        end else if (advance && n_grp.valid) begin
            r_grp <= n_grp;
            r_idx <= '0;
        end else if (out_fire) begin
            if (grp_last) begin
                r_grp.valid <= 1'b0;
                r_idx       <= '0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // Output beat straight from the group register.
    assign m_axis_tvalid   = r_grp.valid;
    assign m_axis_tdata    = r_grp.chars[r_idx];
    assign m_axis_tlast    = grp_last;
    assign m_axis_tuser[0] = grp_last && r_grp.word_end;
    assign m_axis_tuser[1] = r_grp.err;

`ifndef SYNTHESIS
    // The carried nibble count never reaches three.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.cnt != 2'd3)
        else $error("nibble count out of range");

    // A two-result group never indexes past its second entry.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_grp.valid && !r_grp.four |-> r_idx <= ht64_pkg::IDX_LAST_TWO)
        else $error("group index past end");

    // The end of a word clears the carried state.
    a_word_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_end |=> r_state.cnt == ht64_pkg::CNT_NONE && !r_state.err)
        else $error("word state not cleared at word end");

    // The group register is never overwritten while its group cannot be taken.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_grp.valid && !out_fire |=> $stable(r_grp.chars) || !$past(advance && n_grp.valid))
        else $error("group register overwritten");
`endif

endmodule
